>>> hdl/tph_pkg.sv
package tph_pkg;

	localparam int PLAYERS   = 16;
	localparam int HISTORY   = 64;
	localparam int FRAC_BITS = 16;

	localparam int PW    = $clog2(PLAYERS);
	localparam int SW    = $clog2(HISTORY);
	localparam int CW    = $clog2(HISTORY + 1);
	localparam int DEPTH = PLAYERS * HISTORY;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = 32 + FRAC_BITS;
	localparam int QW    = FRAC_BITS + 1;
	localparam int DCW   = $clog2(QW + 1);

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_FORGET = 2'd1;
	localparam logic [1:0] OP_BOX    = 2'd2;
	localparam logic [1:0] OP_COUNT  = 2'd3;

	localparam logic [1:0] REG_HALF_X = 2'd0;
	localparam logic [1:0] REG_HALF_Y = 2'd1;
	localparam logic [1:0] REG_HALF_Z = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [3:0]         player;
		logic [31:0]        tick;
		logic [47:0]        instant;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
		logic [6:0]         sample_count;
	} out_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic rd_new;
		logic rd_first;
		logic rd_next;
		logic save_new;
		logic save_prev;
		logic div_start;
		logic div_step;
		logic mul_start;
		logic mul_step;
		logic use_new;
		logic set_found;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       n_zero;
		logic       miss;
		logic       at_new;
		logic       past;
		logic       k_last;
		logic       div_done;
		logic       mul_done;
		logic       out_free;
	} sts_t;

endpackage

>>> hdl/timestamped_position_history.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_data (in_t)
// out     | output    | out_valid/out_stall | out_data (out_t)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// record, forget, count and a box query with no samples go from decode to finish, where the
// result register loads. a box query reads the newest, then the oldest sample, and finishes
// on a miss or a hit at or after the newest sample; else it scans, runs the 17-step divider
// (only if the ticks rise and the instant passes the earlier one) and the multiply.
// one item at a time; the next item is taken once the result sits in the output register.
// reset clears the count and ring-start flops at once; sample memory is not cleared.
module timestamped_position_history (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tph_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output tph_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [30:0]   cfg_data
);
	import tph_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tph_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> hdl/tph_ctrl.sv
module tph_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tph_pkg::sts_t sts,
	output tph_pkg::cmd_t cmd
);
	import tph_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_RNEW = 4'd2;
	localparam logic [3:0] S_R0   = 4'd3;
	localparam logic [3:0] S_SCAN = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;

	logic [3:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.op == OP_BOX && !sts.n_zero) begin
					cmd.rd_new = 1'b1;
					state_d    = S_RNEW;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_RNEW: begin
				cmd.save_new = 1'b1;
				cmd.rd_first = 1'b1;
				state_d      = S_R0;
			end
			S_R0: begin
				if (sts.miss) begin
					state_d = S_FIN;
				end else if (sts.at_new) begin
					cmd.use_new   = 1'b1;
					cmd.set_found = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.save_prev = 1'b1;
					cmd.rd_next   = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.past) begin
					if (sts.k_last) begin
						cmd.use_new   = 1'b1;
						cmd.set_found = 1'b1;
						state_d       = S_FIN;
					end else begin
						cmd.save_prev = 1'b1;
						cmd.rd_next   = 1'b1;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.mul_start = 1'b1;
					state_d       = S_MUL;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_done) begin
					cmd.set_found = 1'b1;
					state_d       = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/tph_dp.sv
module tph_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  tph_pkg::in_t  in_data,
	input  tph_pkg::cmd_t cmd,
	output tph_pkg::sts_t sts,
	input  logic          cfg_valid,
	input  logic [1:0]    cfg_index,
	input  logic [30:0]   cfg_data,
	output logic          out_valid,
	input  logic          out_stall,
	output tph_pkg::out_t out_data
);
	import tph_pkg::*;

	typedef struct packed {
		logic [31:0]        tick;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} smp_t;

	logic [30:0] half_x_q, half_y_q, half_z_q;
	in_t         item_q;
	logic [CW-1:0] held_q [PLAYERS];
	logic [SW-1:0] old_q  [PLAYERS];
	smp_t        mem [DEPTH];
	smp_t        rd_q, new_q, prev_q, cur_q;
	logic [CW-1:0] k_q;
	logic [TW-1:0] num_q, den_q;
	logic [QW-1:0] quo_q;
	logic [DCW-1:0] dcnt_q;
	logic [1:0]  ax_q;
	logic signed [50:0] prod_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] pos_q [3];
	logic        found_q;
	logic        out_valid_q;
	out_t        out_q;

	logic          pl_ok;
	logic [PW-1:0] pidx;
	logic [CW-1:0] n;
	logic [SW-1:0] oldest;
	logic [TW-1:0] inst;
	logic          we, re;
	logic [AW-1:0] wa, ra;
	logic [CW-1:0] rk;
	logic [SW-1:0] woff;

	function automatic logic [SW-1:0] ring(input logic [SW-1:0] o, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(o) + (CW+1)'(k);
		if (s >= (CW+1)'(HISTORY)) s = s - (CW+1)'(HISTORY);
		return s[SW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr(input logic [PW-1:0] p, input logic [SW-1:0] off);
		return AW'(p) * AW'(HISTORY) + AW'(off);
	endfunction

	function automatic logic [TW-1:0] tscale(input logic [31:0] t);
		return {t, {FRAC_BITS{1'b0}}};
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7fffffff;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	assign pl_ok  = (32'(item_q.player) < PLAYERS);
	assign pidx   = item_q.player[PW-1:0];
	assign n      = pl_ok ? held_q[pidx] : '0;
	assign oldest = old_q[pidx];
	assign inst   = TW'(item_q.instant);

	assign woff = (n >= CW'(HISTORY)) ? oldest : ring(oldest, n);
	assign we   = cmd.exec && item_q.opcode == OP_RECORD && pl_ok;
	assign wa   = addr(pidx, woff);
	assign rk   = cmd.rd_new ? (n - CW'(1)) : (cmd.rd_first ? '0 : k_q + CW'(1));
	assign re   = cmd.rd_new || cmd.rd_first || cmd.rd_next;
	assign ra   = addr(pidx, ring(oldest, rk));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= {item_q.tick, item_q.pos_x, item_q.pos_y, item_q.pos_z};
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign sts.op       = item_q.opcode;
	assign sts.n_zero   = (n == '0);
	assign sts.miss     = inst < tscale(rd_q.tick);
	assign sts.at_new   = inst >= tscale(new_q.tick);
	assign sts.past     = inst > tscale(rd_q.tick);
	assign sts.k_last   = (CW+1)'(k_q) + (CW+1)'(1) >= (CW+1)'(n);
	assign sts.div_done = (dcnt_q == '0);
	assign sts.mul_done = (ax_q == 2'd3);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_x_q <= 31'd32768;
			half_y_q <= 31'd32768;
			half_z_q <= 31'd32768;
			for (int i = 0; i < PLAYERS; i++) begin
				held_q[i] <= '0;
				old_q[i]  <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_HALF_X: half_x_q <= cfg_data;
					REG_HALF_Y: half_y_q <= cfg_data;
					REG_HALF_Z: half_z_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.exec && pl_ok) begin
				case (item_q.opcode)
					OP_RECORD: begin
						if (n >= CW'(HISTORY)) begin
							old_q[pidx] <= ring(oldest, CW'(1));
						end else begin
							held_q[pidx] <= n + CW'(1);
						end
					end
					OP_FORGET: begin
						held_q[pidx] <= '0;
						old_q[pidx]  <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic signed [32:0] dif;
	logic signed [31:0] ma, mb;
	logic signed [50:0] rnd;
	logic [TW-1:0] pt;
	logic [TW:0]   trial;

	always_comb begin
		case (ax_q)
			2'd0:    begin ma = prev_q.x; mb = cur_q.x; end
			2'd1:    begin ma = prev_q.y; mb = cur_q.y; end
			default: begin ma = prev_q.z; mb = cur_q.z; end
		endcase
		dif   = 33'(mb) - 33'(ma);
		rnd   = prod_s1 + (51'sd1 <<< (FRAC_BITS - 1));
		pt    = tscale(prev_q.tick);
		trial = {1'b0, num_q} - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= in_data;
			found_q <= 1'b0;
		end
		if (cmd.save_new) new_q <= rd_q;
		if (cmd.rd_first) k_q <= '0;
		if (cmd.rd_next)  k_q <= k_q + CW'(1);
		if (cmd.save_prev) prev_q <= rd_q;
		if (cmd.div_start) begin
			cur_q <= rd_q;
			quo_q <= '0;
			if (rd_q.tick > prev_q.tick && inst > pt) begin
				num_q  <= inst - pt;
				den_q  <= tscale(rd_q.tick - prev_q.tick);
				dcnt_q <= DCW'(QW);
			end else begin
				dcnt_q <= '0;
			end
		end
		if (cmd.div_step) begin
			if (!trial[TW]) begin
				num_q <= trial[TW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			den_q  <= den_q >> 1;
			dcnt_q <= dcnt_q - DCW'(1);
		end
		if (cmd.mul_start) ax_q <= 2'd0;
		if (cmd.mul_step) begin
			if (ax_q != 2'd3) begin
				prod_s1 <= 51'(dif) * 51'($signed({1'b0, quo_q}));
				a_s1    <= ma;
				ax_q    <= ax_q + 2'd1;
			end
			if (ax_q != 2'd0) begin
				pos_q[ax_q - 2'd1] <= a_s1 + 32'(rnd >>> FRAC_BITS);
			end
		end
		if (cmd.use_new) begin
			pos_q[0] <= new_q.x;
			pos_q[1] <= new_q.y;
			pos_q[2] <= new_q.z;
		end
		if (cmd.set_found) found_q <= 1'b1;
		if (cmd.out_load) begin
			out_q.found        <= found_q;
			out_q.min_x        <= found_q ? sat(34'(pos_q[0]) - 34'(half_x_q)) : '0;
			out_q.min_y        <= found_q ? sat(34'(pos_q[1]) - 34'(half_y_q)) : '0;
			out_q.min_z        <= found_q ? sat(34'(pos_q[2]) - 34'(half_z_q)) : '0;
			out_q.max_x        <= found_q ? sat(34'(pos_q[0]) + 34'(half_x_q)) : '0;
			out_q.max_y        <= found_q ? sat(34'(pos_q[1]) + 34'(half_y_q)) : '0;
			out_q.max_z        <= found_q ? sat(34'(pos_q[2]) + 34'(half_z_q)) : '0;
			out_q.sample_count <= 7'(n);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tph_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;

	timestamped_position_history DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] ring_tick [DEPTH];
	logic [31:0] ring_x [DEPTH];
	logic [31:0] ring_y [DEPTH];
	logic [31:0] ring_z [DEPTH];
	int unsigned ring_start [PLAYERS];
	int unsigned ring_fill [PLAYERS];
	longint half_x, half_y, half_z;

	in_t pending_items[$];
	out_t expected_boxes[$];
	int errors;
	int mismatches;
	int idle_cycles;
	bit hold_off;
	bit stim_done;
	bit in_taken;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned slot_at(int unsigned p, int unsigned k);
		return p * HISTORY + (ring_start[p] + k) % HISTORY;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic longint lerp_pos(logic [31:0] a, logic [31:0] b, longint t);
		longint sa, d, v;
		sa = longint'($signed(a));
		d = longint'($signed(b)) - sa;
		v = d * t + (64'sd1 <<< (FRAC_BITS - 1));
		return sa + (v >>> FRAC_BITS);
	endfunction

	function automatic out_t predict_box(in_t it);
		out_t r;
		int unsigned p, n, s, s0, sn, a, b;
		logic [63:0] inst, pt;
		longint px, py, pz, t;
		r = '0;
		p = it.player;
		n = ring_fill[p];
		if (it.opcode == OP_RECORD) begin
			if (n >= HISTORY) begin
				s = slot_at(p, 0);
				ring_start[p] = (ring_start[p] + 1) % HISTORY;
			end else begin
				s = slot_at(p, n);
				n++;
				ring_fill[p] = n;
			end
			ring_tick[s] = it.tick;
			ring_x[s] = it.pos_x;
			ring_y[s] = it.pos_y;
			ring_z[s] = it.pos_z;
		end else if (it.opcode == OP_FORGET) begin
			ring_fill[p] = 0;
			ring_start[p] = 0;
			n = 0;
		end else if (it.opcode == OP_BOX && n > 0) begin
			inst = {16'd0, it.instant};
			s0 = slot_at(p, 0);
			sn = slot_at(p, n - 1);
			if (inst >= ({32'd0, ring_tick[s0]} << FRAC_BITS)) begin
				px = longint'($signed(ring_x[sn]));
				py = longint'($signed(ring_y[sn]));
				pz = longint'($signed(ring_z[sn]));
				if (inst < ({32'd0, ring_tick[sn]} << FRAC_BITS)) begin
					for (int k = 1; k < n; k++) begin
						a = slot_at(p, k - 1);
						b = slot_at(p, k);
						pt = {32'd0, ring_tick[a]} << FRAC_BITS;
						t = 0;
						if (inst > ({32'd0, ring_tick[b]} << FRAC_BITS)) continue;
						if (ring_tick[b] > ring_tick[a] && inst > pt) begin
							t = longint'((inst - pt) / {32'd0, ring_tick[b] - ring_tick[a]});
							if (t > (64'sd1 <<< FRAC_BITS)) t = 64'sd1 <<< FRAC_BITS;
						end
						px = lerp_pos(ring_x[a], ring_x[b], t);
						py = lerp_pos(ring_y[a], ring_y[b], t);
						pz = lerp_pos(ring_z[a], ring_z[b], t);
						break;
					end
				end
				r.found = 1'b1;
				r.min_x = clamp32(px - half_x);
				r.min_y = clamp32(py - half_y);
				r.min_z = clamp32(pz - half_z);
				r.max_x = clamp32(px + half_x);
				r.max_y = clamp32(py + half_y);
				r.max_z = clamp32(pz + half_z);
			end
		end
		r.sample_count = n[6:0];
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		logic [191:0] junk;
		if (arst_n) begin
			if (in_taken) begin
				pending_items.delete(0);
			end
			if (in_valid && !in_taken) begin
			end else if (pending_items.size() > 0 && ($urandom_range(0, 3) != 0 ||
					hold_off)) begin
				in_valid <= 1'b1;
				in_data <= pending_items[0];
			end else begin
				junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				in_valid <= 1'b0;
				in_data <= in_t'(junk[$bits(in_t)-1:0]);
			end
		end
	end

	// receiver stall pattern
	int stall_left;
	int hold_count;
	always @(negedge clk) begin
		if (hold_count > 0) begin
			hold_count <= hold_count - 1;
			hold_off <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_off) begin
			hold_off <= 1'b0;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) :
				$urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_boxes = {expected_boxes, predict_box(in_data)};
				idle_cycles <= 0;
			end
			if (cfg_valid && cfg_ready) begin
				idle_cycles <= 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles <= 0;
				if (expected_boxes.size() == 0) begin
					errors++;
					$display("unexpected item %h", out_data);
				end else begin
					want = expected_boxes[0];
					expected_boxes.delete(0);
					if (want !== out_data) begin
						errors++;
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected %h actual %h", want, out_data);
						end
					end
				end
			end
			if (idle_cycles > 20000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic add_item(in_t it);
		pending_items = {pending_items, it};
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_boxes.size() > 0) begin
			@(posedge clk);
		end
		repeat (120) @(posedge clk);
	endtask

	task automatic write_half(logic [1:0] idx, logic [30:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_HALF_X: half_x = longint'(v);
			REG_HALF_Y: half_y = longint'(v);
			default: half_z = longint'(v);
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t make_item(logic [1:0] op, logic [3:0] p, logic [31:0] tk,
			logic [47:0] inst);
		in_t it;
		it.opcode = op;
		it.player = p;
		it.tick = tk;
		it.instant = inst;
		it.pos_x = rand_pos();
		it.pos_y = rand_pos();
		it.pos_z = rand_pos();
		return it;
	endfunction

	function automatic logic [30:0] rand_half();
		case ($urandom_range(0, 3))
			0: return 31'h7fffffff;
			1: return 31'd0;
			default: return 31'($urandom_range(0, 500000));
		endcase
	endfunction

	logic [31:0] base_tick [PLAYERS];

	initial begin
		logic [1:0] op;
		logic [3:0] p;
		logic [31:0] tk;
		logic [47:0] inst;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = REG_HALF_X;
		cfg_data = '0;
		errors = 0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 0;
		in_taken = 0;
		stall_left = 0;
		hold_count = 0;
		half_x = 32768;
		half_y = 32768;
		half_z = 32768;
		for (int i = 0; i < PLAYERS; i++) begin
			ring_start[i] = 0;
			ring_fill[i] = 0;
			base_tick[i] = $urandom_range(0, 1000);
		end
		repeat (10) @(posedge clk);
		arst_n = 1;

		// directed part
		add_item(make_item(OP_BOX, 4'd0, 32'd0, 48'd0));
		add_item(make_item(OP_COUNT, 4'd0, 32'd0, 48'd0));
		add_item(make_item(OP_RECORD, 4'd0, 32'd100, 48'd0));
		add_item(make_item(OP_RECORD, 4'd0, 32'd100, 48'd0));
		add_item(make_item(OP_RECORD, 4'd0, 32'd110, 48'd0));
		add_item(make_item(OP_RECORD, 4'd0, 32'd105, 48'd0));
		add_item(make_item(OP_RECORD, 4'd0, 32'hffffffff, 48'd0));
		add_item(make_item(OP_BOX, 4'd0, 32'd0, 48'd99 << 16));
		add_item(make_item(OP_BOX, 4'd0, 32'd0, 48'd100 << 16));
		add_item(make_item(OP_BOX, 4'd0, 32'd0, (48'd100 << 16) + 48'h7fff));
		add_item(make_item(OP_BOX, 4'd0, 32'd0, (48'd106 << 16) + 48'h1));
		add_item(make_item(OP_BOX, 4'd0, 32'd0, 48'hffffffffffff));
		add_item(make_item(OP_BOX, 4'd0, 32'd0, 48'hfffeffffffff));
		add_item(make_item(OP_COUNT, 4'd0, 32'd0, 48'd0));
		for (int i = 0; i < 66; i++) begin
			add_item(make_item(OP_RECORD, 4'd15, 32'(i * 3), 48'd0));
		end
		add_item(make_item(OP_BOX, 4'd15, 32'd0, 48'd10 << 16));
		add_item(make_item(OP_BOX, 4'd15, 32'd0, 48'd100 << 16));
		add_item(make_item(OP_FORGET, 4'd15, 32'd0, 48'd0));
		add_item(make_item(OP_BOX, 4'd15, 32'd0, 48'd100 << 16));
		wait_drained();
		write_half(REG_HALF_X, 31'h7fffffff);
		write_half(REG_HALF_Y, 31'd0);
		write_half(REG_HALF_Z, 31'd12345);
		add_item(make_item(OP_BOX, 4'd0, 32'd0, (48'd102 << 16) + 48'h3));
		add_item(make_item(OP_BOX, 4'd0, 32'd0, 48'hffffffffffff));

		// random part in phases, with mostly non-decreasing tick streams per player
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			write_half(REG_HALF_X, rand_half());
			write_half(REG_HALF_Y, rand_half());
			write_half(REG_HALF_Z, rand_half());
			if (ph == 2) begin
				hold_count = 400;
			end
			for (int i = 0; i < 220; i++) begin
				p = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3));
				case ($urandom_range(0, 19))
					0: op = OP_FORGET;
					1, 2: op = OP_COUNT;
					3, 4, 5, 6, 7, 8, 9: op = OP_BOX;
					default: op = OP_RECORD;
				endcase
				if ($urandom_range(0, 15) == 0) begin
					tk = $urandom;
				end else begin
					tk = base_tick[p] + $urandom_range(0, 5);
					base_tick[p] = tk;
				end
				if ($urandom_range(0, 15) == 0) begin
					inst = 48'({$urandom, $urandom});
				end else begin
					inst = ({16'd0, base_tick[p]} << 16) -
						(48'($urandom_range(0, 80)) << 16) + 48'($urandom_range(0, 65535));
				end
				add_item(make_item(op, p, tk, inst));
			end
		end
		wait_drained();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/tph_pkg.sv
hdl/tph_ctrl.sv
hdl/tph_dp.sv
hdl/timestamped_position_history.sv
tb/testbench.sv
